FILE: hw/rtl/itoc_pkg.sv
`default_nettype none

package itoc_pkg;

	// Width of the saturating tick counter.
	localparam int COUNT_WIDTH = 32;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_PICKUP    = 3'd0;
	localparam logic [2:0] REG_TIME_DIAL = 3'd1;
	localparam logic [2:0] REG_CURVE_A   = 3'd2;
	localparam logic [2:0] REG_CURVE_B   = 3'd3;
	localparam logic [2:0] REG_CURVE_EXP = 3'd4;
	localparam logic [2:0] REG_TICKS     = 3'd5;

	// Fixed-point and iteration constants.
	localparam int          LOG_STEPS = 24;
	localparam int          DIV_W     = 56;
	localparam int          DEN_W     = 60;
	localparam logic [12:0] EXP_LIMIT = 13'd36;
	localparam logic [59:0] Q24_ONE   = 60'd1 << 24;
	localparam logic [30:0] Q30_ONE   = 31'd1 << 30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG,
		ST_MULY,
		ST_EXP,
		ST_DEN,
		ST_DIV,
		ST_SUM,
		ST_MUL0,
		ST_MUL1,
		ST_PSUM,
		ST_MUL2,
		ST_MUL3,
		ST_TSUM,
		ST_CMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [4:0]  p;
		logic [30:0] m;
	} norm_t;

	typedef logic [23:0][30:0] root_tab_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] rem;
		int i;
		rem = v;
		res = 64'd0;
		bit_v = 64'h4000_0000_0000_0000;
		for (i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Entry k is 2^(2^-(k+1)) in Q1.30, each the floor square root of the one before.
	function automatic root_tab_t build_root_table();
		root_tab_t t;
		logic [63:0] e;
		int k;
		e = isqrt64(64'd2 << 60);
		t[0] = e[30:0];
		for (k = 1; k < 24; k++) begin
			e = isqrt64({3'b000, e[30:0], 30'd0});
			t[k] = e[30:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TABLE = build_root_table();

endpackage

`default_nettype wire

FILE: hw/rtl/itoc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module itoc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [itoc_pkg::DIV_W-1:0]  dividend,
	input  wire logic [itoc_pkg::DEN_W-1:0]  divisor,
	output itoc_pkg::div_stat_t              stat,
	output logic      [itoc_pkg::DIV_W-1:0]  quotient
);

	logic                       busy_q;
	logic                       done_q;
	logic [5:0]                 cnt_q;
	logic [itoc_pkg::DEN_W-1:0] rem_q;
	logic [itoc_pkg::DEN_W-1:0] den_q;
	logic [itoc_pkg::DIV_W-1:0] nq_q;
	logic [itoc_pkg::DEN_W:0]   trial;
	logic [itoc_pkg::DEN_W:0]   diff;
	logic                       ge;

	assign trial = {rem_q, nq_q[itoc_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(itoc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[itoc_pkg::DEN_W-1:0] : trial[itoc_pkg::DEN_W-1:0];
			nq_q  <= {nq_q[itoc_pkg::DIV_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = nq_q;

endmodule

`default_nettype wire

FILE: hw/rtl/inverse_time_overcurrent_trip.sv
`default_nettype none

// Inverse-time overcurrent element. Each accepted word is one period tick with a
// current magnitude in unsigned Q16.16. While the magnitude is strictly above the
// pickup level a saturating tick counter runs, and the trip latches once the count
// exceeds ticks_per_second * td * (a + b / ((I/pickup)^c - 1)); at or below pickup
// the counter and latch clear. Exactly one result word (pickup_flag, trip_flag)
// leaves per tick. A tick at or below pickup, or one that arrives already tripped,
// goes straight to the finish state. A tick that needs the curve runs two 24-step
// log2 squaring loops and a 24-step exp2 loop on the one shared 33x33 multiplier,
// then a 56-step restoring divider that holds the sequencer until it finishes, then
// the four partial products of the threshold on the same multiplier. When the
// exponent is huge the exp2 and divide are skipped, and a zero denominator ends
// the tick after the exp2 loop without a trip decision. The block takes one tick
// at a time; it does not accept a word until the previous tick has left its result
// in the output register, so a stalled receiver adds its stall cycles.
// Configuration words are accepted in every cycle and must only be sent
// while the block is idle.
module inverse_time_overcurrent_trip (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] magnitude,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             pickup_flag,
	output logic             trip_flag
);

	// Configuration registers.
	logic [31:0] pickup_q;
	logic [31:0] td_q;
	logic [31:0] ca_q;
	logic [31:0] cb_q;
	logic [31:0] cexp_q;
	logic [19:0] ticks_q;

	// Element state.
	logic [itoc_pkg::COUNT_WIDTH-1:0] elapsed_q;
	logic                             latch_q;
	logic                             pick_q;

	// Sequencer and datapath registers.
	itoc_pkg::state_t state_q, state_d;
	logic [4:0]   step_q;
	logic         sel_q;
	logic [30:0]  m_q;
	logic [4:0]   ip_q;
	logic [23:0]  fr_q;
	logic [28:0]  lm_q;
	logic [28:0]  d_q;
	logic [23:0]  f_q;
	logic [5:0]   n_q;
	logic         qz_q;
	logic [30:0]  acc_q;
	logic [56:0]  s_q;
	logic [63:0]  pl_q;
	logic [56:0]  ph_q;
	logic [64:0]  p_q;
	logic [51:0]  tl_q;
	logic [52:0]  th_q;
	logic [61:0]  thr_q;

	// Output register.
	logic out_valid_q;
	logic out_pick_q;
	logic out_trip_q;

	// Shared multiplier.
	logic [32:0] mul_a;
	logic [32:0] mul_b;
	logic [65:0] mul_p;

	// Divider.
	logic                       div_start;
	itoc_pkg::div_stat_t        div_stat;
	logic [itoc_pkg::DIV_W-1:0] div_q;
	logic [itoc_pkg::DEN_W-1:0] den;
	logic [itoc_pkg::DEN_W-1:0] big;

	logic        in_acc;
	logic        pick_now;
	logic        out_free;
	logic        sq_hi;
	logic [31:0] sq;
	logic [23:0] fr_next;
	logic [28:0] log_val;
	logic        huge;
	itoc_pkg::norm_t norm_in;
	itoc_pkg::norm_t norm_pk;

	// Normalizes a raw value to Q1.30 and gives the index of its top set bit.
	// Zero normalizes to zero, so its logarithm comes out as zero.
	function automatic itoc_pkg::norm_t normalize(logic [31:0] x);
		itoc_pkg::norm_t r;
		logic [31:0] sh;
		int i;
		r.p = 5'd0;
		for (i = 0; i < 32; i++) begin
			if (x[i]) begin
				r.p = 5'(i);
			end
		end
		sh = x << (5'd30 - r.p);
		if (r.p == 5'd31) begin
			r.m = x[31:1];
		end else begin
			r.m = sh[30:0];
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign norm_in   = normalize(magnitude);
	assign norm_pk   = normalize(pickup_q);
	assign pick_now  = magnitude > pickup_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// One squaring step of the log2 fraction.
	assign sq      = mul_p[61:30];
	assign sq_hi   = sq[31];
	assign fr_next = {fr_q[22:0], sq_hi};
	assign log_val = {ip_q, fr_next};
	assign huge    = mul_p[60:48] >= itoc_pkg::EXP_LIMIT;

	// Denominator 2^y - 1 in Q.24.
	assign big = {35'd0, acc_q[30:6]} << n_q;
	assign den = big - itoc_pkg::Q24_ONE;

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickup_q <= 32'd65536;
			td_q     <= 32'd16777216;
			ca_q     <= 32'd864027;
			cb_q     <= 32'd1912603;
			cexp_q   <= 32'd335544;
			ticks_q  <= 20'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				itoc_pkg::REG_PICKUP:    pickup_q <= cfg_data;
				itoc_pkg::REG_TIME_DIAL: td_q     <= cfg_data;
				itoc_pkg::REG_CURVE_A:   ca_q     <= cfg_data;
				itoc_pkg::REG_CURVE_B:   cb_q     <= cfg_data;
				itoc_pkg::REG_CURVE_EXP: cexp_q   <= cfg_data;
				itoc_pkg::REG_TICKS:     ticks_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (pick_now && !latch_q) begin
						state_d = itoc_pkg::ST_LOG;
					end else begin
						state_d = itoc_pkg::ST_FINISH;
					end
				end
			end
			itoc_pkg::ST_LOG: begin
				if (step_q == 5'(itoc_pkg::LOG_STEPS - 1) && sel_q) begin
					state_d = itoc_pkg::ST_MULY;
				end
			end
			itoc_pkg::ST_MULY: begin
				state_d = huge ? itoc_pkg::ST_SUM : itoc_pkg::ST_EXP;
			end
			itoc_pkg::ST_EXP: begin
				if (step_q == 5'(itoc_pkg::LOG_STEPS - 1)) begin
					state_d = itoc_pkg::ST_DEN;
				end
			end
			itoc_pkg::ST_DEN: begin
				state_d = (den == '0) ? itoc_pkg::ST_FINISH : itoc_pkg::ST_DIV;
			end
			itoc_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = itoc_pkg::ST_SUM;
				end
			end
			itoc_pkg::ST_SUM:  state_d = itoc_pkg::ST_MUL0;
			itoc_pkg::ST_MUL0: state_d = itoc_pkg::ST_MUL1;
			itoc_pkg::ST_MUL1: state_d = itoc_pkg::ST_PSUM;
			itoc_pkg::ST_PSUM: state_d = itoc_pkg::ST_MUL2;
			itoc_pkg::ST_MUL2: state_d = itoc_pkg::ST_MUL3;
			itoc_pkg::ST_MUL3: state_d = itoc_pkg::ST_TSUM;
			itoc_pkg::ST_TSUM: state_d = itoc_pkg::ST_CMP;
			itoc_pkg::ST_CMP:  state_d = itoc_pkg::ST_FINISH;
			itoc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = itoc_pkg::ST_IDLE;
				end
			end
			default: state_d = itoc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider start and multiplier operands.
	always_comb begin
		in_ready  = state_q == itoc_pkg::ST_IDLE;
		div_start = (state_q == itoc_pkg::ST_DEN) && (den != '0);
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			itoc_pkg::ST_LOG: begin
				mul_a = {2'b00, m_q};
				mul_b = {2'b00, m_q};
			end
			itoc_pkg::ST_MULY: begin
				mul_a = {1'b0, cexp_q};
				mul_b = {4'd0, d_q};
			end
			itoc_pkg::ST_EXP: begin
				mul_a = {2'b00, acc_q};
				mul_b = {2'b00, itoc_pkg::ROOT_TABLE[step_q]};
			end
			itoc_pkg::ST_MUL0: begin
				mul_a = {1'b0, td_q};
				mul_b = {1'b0, s_q[31:0]};
			end
			itoc_pkg::ST_MUL1: begin
				mul_a = {1'b0, td_q};
				mul_b = {8'd0, s_q[56:32]};
			end
			itoc_pkg::ST_MUL2: begin
				mul_a = {13'd0, ticks_q};
				mul_b = {1'b0, p_q[31:0]};
			end
			itoc_pkg::ST_MUL3: begin
				mul_a = {13'd0, ticks_q};
				mul_b = p_q[64:32];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoc_pkg::ST_IDLE;
			elapsed_q   <= '0;
			latch_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (pick_now) begin
					if (elapsed_q != '1) begin
						elapsed_q <= elapsed_q + 1'b1;
					end
				end else begin
					elapsed_q <= '0;
					latch_q   <= 1'b0;
				end
			end
			// The trip decision uses the count that already includes this tick.
			if (state_q == itoc_pkg::ST_CMP &&
			    64'(elapsed_q) > 64'(thr_q)) begin
				latch_q <= 1'b1;
			end
			if (state_q == itoc_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pick_q <= pick_now;
			m_q    <= norm_in.m;
			ip_q   <= norm_in.p;
			fr_q   <= '0;
			step_q <= '0;
			sel_q  <= 1'b0;
		end
		unique case (state_q)
			itoc_pkg::ST_LOG: begin
				if (step_q == 5'(itoc_pkg::LOG_STEPS - 1)) begin
					step_q <= '0;
					if (!sel_q) begin
						// First log done; start on the pickup level.
						lm_q  <= log_val;
						m_q   <= norm_pk.m;
						ip_q  <= norm_pk.p;
						fr_q  <= '0;
						sel_q <= 1'b1;
					end else begin
						d_q <= lm_q - log_val;
					end
				end else begin
					m_q    <= sq_hi ? sq[31:1] : sq[30:0];
					fr_q   <= fr_next;
					step_q <= step_q + 5'd1;
				end
			end
			itoc_pkg::ST_MULY: begin
				f_q    <= mul_p[47:24];
				n_q    <= mul_p[53:48];
				qz_q   <= huge;
				acc_q  <= itoc_pkg::Q30_ONE;
				step_q <= '0;
			end
			itoc_pkg::ST_EXP: begin
				if (f_q[5'd23 - step_q]) begin
					acc_q <= mul_p[60:30];
				end
				step_q <= step_q + 5'd1;
			end
			itoc_pkg::ST_SUM: begin
				s_q <= {25'd0, ca_q} + (qz_q ? 57'd0 : {1'b0, div_q});
			end
			itoc_pkg::ST_MUL0: pl_q <= mul_p[63:0];
			itoc_pkg::ST_MUL1: ph_q <= mul_p[56:0];
			itoc_pkg::ST_PSUM: p_q  <= {ph_q, 8'd0} + {25'd0, pl_q[63:24]};
			itoc_pkg::ST_MUL2: tl_q <= mul_p[51:0];
			itoc_pkg::ST_MUL3: th_q <= mul_p[52:0];
			itoc_pkg::ST_TSUM: thr_q <= {1'b0, th_q, 8'd0} + {34'd0, tl_q[51:24]};
			default: ;
		endcase
		if (state_q == itoc_pkg::ST_FINISH && out_free) begin
			out_pick_q <= pick_q;
			out_trip_q <= latch_q;
		end
	end

	itoc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({cb_q, 24'd0}),
		.divisor  (den),
		.stat     (div_stat),
		.quotient (div_q)
	);

	assign out_valid   = out_valid_q;
	assign pickup_flag = out_pick_q;
	assign trip_flag   = out_trip_q;

	// A trip is never reported without pickup.
	a_trip_needs_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!trip_flag || pickup_flag))
		else $error("trip reported without pickup");

	// The divider only runs while the sequencer waits on it.
	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == itoc_pkg::ST_DIV)
		else $error("divider busy outside the divide state");

	// A tick at or below pickup clears the counter and the latch.
	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !pick_now) |=> (elapsed_q == '0 && !latch_q))
		else $error("drop-out did not clear the element");

	// The latch only sets on a tick above pickup.
	a_latch_on_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(latch_q) |-> pick_q)
		else $error("trip latched without pickup");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Testbench for the inverse-time overcurrent element. A directed table covers the
// register extremes and the special cases of the curve, then random ticks follow
// in several idling phases. Each result word is compared with a predictor that
// computes the curve threshold in the same truncating fixed point.
module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] magnitude;
	logic        out_valid;
	logic        out_ready;
	logic        pickup_flag;
	logic        trip_flag;

	inverse_time_overcurrent_trip dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .magnitude(magnitude),
		.out_valid(out_valid), .out_ready(out_ready),
		.pickup_flag(pickup_flag), .trip_flag(trip_flag)
	);

	typedef struct packed {
		logic pickup;
		logic trip;
	} flags_t;

	// Predictor copy of the registers and the element state.
	logic [31:0] pk_level, td_mult, a_const, b_const, c_exp;
	logic [19:0] tick_rate;
	logic [63:0] tick_count;
	logic        latched;
	logic [63:0] sqrt_tab [24];

	flags_t flags_due [$];
	int     errors;
	int     send_idle;   // percent of cycles the sender holds back
	int     recv_stall;  // percent of cycles the receiver stalls

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Integer part is the top set bit; the fraction comes from repeated squaring.
	function automatic logic [63:0] log2_fixed(logic [31:0] x);
		int p;
		logic [63:0] m, fr;
		if (x == 0) return 0;
		p = 31;
		while (!x[p]) p--;
		m = (p <= 30) ? ({32'd0, x} << (30 - p)) : ({32'd0, x} >> 1);
		fr = 0;
		for (int k = 0; k < 24; k++) begin
			m = (m * m) >> 30;
			fr <<= 1;
			if (m >= 64'd2 << 30) begin
				fr |= 1;
				m >>= 1;
			end
		end
		return (64'(p) << 24) | fr;
	endfunction

	// Returns 0 when the denominator vanishes, so no trip can be decided.
	function automatic bit trip_threshold(logic [31:0] mag, output logic [63:0] thr);
		logic [63:0] d, y, n, f, q, s, h, l, r, p_hi, p_lo, acc, big, den;
		logic [127:0] prod;
		d = log2_fixed(mag) - log2_fixed(pk_level);
		prod = {64'd0, 32'd0, c_exp} * {64'd0, d};
		y = prod[87:24];
		n = y >> 24;
		f = y & 64'hFF_FFFF;
		if (n >= 36) begin
			q = 0;
		end else begin
			acc = 64'd1 << 30;
			for (int k = 0; k < 24; k++)
				if (f[23 - k]) acc = (acc * sqrt_tab[k]) >> 30;
			big = (acc >> 6) << n;
			den = big - (64'd1 << 24);
			if (den == 0) return 0;
			q = ({32'd0, b_const} << 24) / den;
		end
		s = {32'd0, a_const} + q;
		h = {32'd0, td_mult} * (s >> 32);
		l = {32'd0, td_mult} * (s & 64'hFFFF_FFFF);
		r = ((h & 64'hFFFF) << 8) + (l >> 24);
		p_hi = (h >> 16) + (r >> 24);
		p_lo = r & 64'hFF_FFFF;
		thr = {44'd0, tick_rate} * p_hi + (({44'd0, tick_rate} * p_lo) >> 24);
		return 1;
	endfunction

	function automatic flags_t predict_tick(logic [31:0] mag);
		flags_t fl;
		logic [63:0] thr;
		if (mag > pk_level) begin
			fl.pickup = 1'b1;
			if (tick_count < 64'hFFFF_FFFF) tick_count++;
			if (trip_threshold(mag, thr) && tick_count > thr) latched = 1'b1;
		end else begin
			fl.pickup = 1'b0;
			tick_count = 0;
			latched = 1'b0;
		end
		fl.trip = latched;
		return fl;
	endfunction

	// Leaves cfg_valid high; the caller drops it once the last write is in.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			itoc_pkg::REG_PICKUP:    pk_level  = val;
			itoc_pkg::REG_TIME_DIAL: td_mult   = val;
			itoc_pkg::REG_CURVE_A:   a_const   = val;
			itoc_pkg::REG_CURVE_B:   b_const   = val;
			itoc_pkg::REG_CURVE_EXP: c_exp     = val;
			itoc_pkg::REG_TICKS:     tick_rate = val[19:0];
			default: ;
		endcase
	endtask

	// Sends one word; the expectation is queued when it is accepted. Valid stays
	// high afterwards so that back-to-back words need no gap; whoever waits next
	// drops it.
	task automatic send_tick(logic [31:0] mag);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid  <= 1'b1;
		magnitude <= mag;
		do @(posedge clk); while (!in_ready);
		flags_due.push_back(predict_tick(mag));
	endtask

	// Settles the block before configuration: every result is in, then a guard gap.
	task automatic drain();
		in_valid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Receiver: random stall, result words checked against the oldest expectation.
	always @(posedge clk) begin
		flags_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (flags_due.size() == 0) begin
					$error("result word with no expectation waiting");
					errors++;
				end else begin
					want = flags_due.pop_front();
					if (pickup_flag !== want.pickup) begin
						$error("pickup_flag expected %0d actual %0d", want.pickup, pickup_flag);
						errors++;
					end
					if (trip_flag !== want.trip) begin
						$error("trip_flag expected %0d actual %0d", want.trip, trip_flag);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Directed rows: a register write when is_cfg is set, otherwise one tick. Where
	// chk is set the typed flags must match the predictor as well.
	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [31:0] val;
		bit          chk;
		flags_t      fl;
	} row_t;

	row_t rows [] = '{
		'{0, 0, 32'h0000_0000, 1, '{0, 0}},  // zero magnitude after reset
		'{0, 0, 32'h0001_0000, 1, '{0, 0}},  // exactly at pickup
		'{0, 0, 32'hFFFF_FFFF, 1, '{1, 0}},  // largest magnitude, first tick
		'{0, 0, 32'hFFFF_FFFF, 0, '{0, 0}},
		'{0, 0, 32'h0001_0001, 0, '{0, 0}},  // ratio rounds to one
		'{0, 0, 32'h0000_FFFF, 1, '{0, 0}},  // clears the latch
		'{1, itoc_pkg::REG_TICKS, 32'd0, 0, '{0, 0}},  // zero tick rate trips at once
		'{0, 0, 32'h0004_0000, 1, '{1, 1}},
		'{0, 0, 32'h0004_0000, 1, '{1, 1}},
		'{1, itoc_pkg::REG_TICKS, 32'hFFFF_FFFF, 0, '{0, 0}},  // masked to 20 bits
		'{1, itoc_pkg::REG_PICKUP, 32'd0, 0, '{0, 0}},  // zero pickup
		'{0, 0, 32'h0000_0001, 0, '{0, 0}},
		'{0, 0, 32'h8000_0000, 0, '{0, 0}},
		'{1, itoc_pkg::REG_CURVE_EXP, 32'hFFFF_FFFF, 0, '{0, 0}},  // huge exponent
		'{0, 0, 32'hFFFF_FFFF, 0, '{0, 0}},
		'{1, itoc_pkg::REG_CURVE_EXP, 32'd0, 0, '{0, 0}},  // zero denominator
		'{0, 0, 32'h0002_0000, 0, '{0, 0}},
		'{1, itoc_pkg::REG_TIME_DIAL, 32'hFFFF_FFFF, 0, '{0, 0}},
		'{1, itoc_pkg::REG_CURVE_A, 32'hFFFF_FFFF, 0, '{0, 0}},
		'{1, itoc_pkg::REG_CURVE_B, 32'hFFFF_FFFF, 0, '{0, 0}},
		'{1, itoc_pkg::REG_CURVE_EXP, 32'h0100_0000, 0, '{0, 0}},
		'{1, itoc_pkg::REG_PICKUP, 32'hFFFF_FFFF, 0, '{0, 0}},  // nothing can exceed it
		'{0, 0, 32'hFFFF_FFFF, 1, '{0, 0}},
		'{1, 3'd7, 32'h1234_5678, 0, '{0, 0}},  // unknown index is ignored
		'{0, 0, 32'hFFFF_FFFF, 1, '{0, 0}}
	};

	// One random setting per phase; mostly gentle curves so trips actually happen.
	task automatic random_setting();
		write_reg(itoc_pkg::REG_PICKUP,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h2_0000, 1));
		write_reg(itoc_pkg::REG_TIME_DIAL,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000));
		write_reg(itoc_pkg::REG_CURVE_A,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000));
		write_reg(itoc_pkg::REG_CURVE_B,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000));
		write_reg(itoc_pkg::REG_CURVE_EXP,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0300_0000, 1));
		write_reg(itoc_pkg::REG_TICKS,
			$urandom_range(3) == 0 ? $urandom : $urandom_range(20, 0));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] mag;
		int burst;
		int unsigned scale;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		magnitude = '0;
		out_ready = 1'b0;
		errors = 0;
		send_idle = 0;
		recv_stall = 0;
		pk_level = 32'd65536;
		td_mult = 32'd16777216;
		a_const = 32'd864027;
		b_const = 32'd1912603;
		c_exp = 32'd335544;
		tick_rate = 20'd1000;
		tick_count = 0;
		latched = 1'b0;
		sqrt_tab[0] = floor_sqrt(64'd2 << 60);
		for (int k = 1; k < 24; k++) sqrt_tab[k] = floor_sqrt(sqrt_tab[k - 1] << 30);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_reg(rows[i].idx, rows[i].val);
				cfg_valid <= 1'b0;
			end else begin
				send_tick(rows[i].val);
				if (rows[i].chk && flags_due[$] != rows[i].fl) begin
					$error("directed row %0d: pickup_flag/trip_flag expected %b actual %b",
						i, rows[i].fl, flags_due[$]);
					errors++;
				end
			end
		end

		// Random part: runs above pickup so the counter reaches the threshold,
		// broken by dips to or below pickup.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 82; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 82; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase
			drain();
			random_setting();
			for (int n = 0; n < 125; n += burst) begin
				burst = $urandom_range(30, 1);
				scale = $urandom_range(3);
				for (int j = 0; j < burst; j++) begin
					case (scale)
						0: mag = $urandom;
						1: mag = pk_level + $urandom_range(3);
						2: mag = pk_level - $urandom_range(1);
						default: mag = pk_level + (pk_level >> $urandom_range(4));
					endcase
					if (pk_level == 32'hFFFF_FFFF && scale != 0) mag = $urandom;
					send_tick(mag);
				end
				// Hold the sender until every outstanding result is in.
				if ($urandom_range(9) == 0) begin
					in_valid <= 1'b0;
					while (flags_due.size() != 0) @(posedge clk);
				end
			end
		end

		drain();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
